>>> hw/rtl/hsv_to_rgb_converter_macros.svh
// Assertion macros for the HSV to RGB converter RTL, included by the top level.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/hsvrgb_pkg.sv
// Types, constants and helpers of the HSV to RGB converter.
package hsvrgb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_FRAC   = 16;
   localparam int SHL       = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
   localparam int SHR       = (FRAC_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRAC_BITS;
   localparam int CH_BITS   = 8;

   localparam logic [IN_FRAC:0]   ONE_IN = (IN_FRAC + 1)'(1) << IN_FRAC;
   localparam logic [FRAC_BITS:0] ONE_F  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [CH_BITS-1:0] CH_MAX = '1;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type             sector;
      logic [FRAC_BITS-1:0]   f;
      logic [FRAC_BITS:0]     s;
      logic [FRAC_BITS:0]     v;
   } s1_type;

   typedef struct packed {
      sector_type             sector;
      logic [FRAC_BITS:0]     v;
      logic [FRAC_BITS:0]     p;
      logic [FRAC_BITS:0]     fs;
      logic [FRAC_BITS:0]     gs;
   } s2_type;

   typedef struct packed {
      sector_type             sector;
      logic [FRAC_BITS:0]     v;
      logic [FRAC_BITS:0]     p;
      logic [FRAC_BITS:0]     q;
      logic [FRAC_BITS:0]     t;
   } s3_type;

   // rescale a Q.16 input (at most one) to FRAC_BITS fraction bits
   function automatic logic [FRAC_BITS:0] to_frac(input logic [IN_FRAC:0] x);
      logic [IN_FRAC+FRAC_BITS:0] w;
      w = (IN_FRAC + FRAC_BITS + 1)'(x) << SHL;
      w = w >> SHR;
      return w[FRAC_BITS:0];
   endfunction

   // (a * b) >> FRAC_BITS for operands of at most one
   function automatic logic [FRAC_BITS:0] fx_mul(input logic [FRAC_BITS:0] a,
                                                 input logic [FRAC_BITS:0] b);
      logic [2*FRAC_BITS+1:0] prod;
      prod = a * b;
      return prod[2*FRAC_BITS:FRAC_BITS];
   endfunction

endpackage

>>> hw/rtl/hsvrgb_prep.sv
// First stage: clamp inputs, split scaled hue into sector and fraction.
module hsvrgb_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [15:0]            hue,
   input  logic [16:0]            sat,
   input  logic [16:0]            bri,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvrgb_pkg::s1_type     out_data
);
   import hsvrgb_pkg::*;

   logic                    valid_ff, valid_in;
   s1_type                  data_ff, data_in;
   logic [IN_FRAC:0]        sat_c, bri_c;
   logic [FRAC_BITS:0]      h_full;
   logic [FRAC_BITS-1:0]    h;
   logic [FRAC_BITS+2:0]    hf;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sat_c  = (sat > ONE_IN) ? ONE_IN : sat;
      bri_c  = (bri > ONE_IN) ? ONE_IN : bri;
      h_full = to_frac({1'b0, hue});
      h      = h_full[FRAC_BITS-1:0];
      // times six as four plus two
      hf     = ((FRAC_BITS + 3)'(h) << 2) + ((FRAC_BITS + 3)'(h) << 1);
      data_in.sector = sector_type'(hf[FRAC_BITS+2:FRAC_BITS]);
      data_in.f      = hf[FRAC_BITS-1:0];
      data_in.s      = to_frac(sat_c);
      data_in.v      = to_frac(bri_c);
      valid_in       = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hw/rtl/hsvrgb_prod.sv
// Second and third stages: the fixed-point products for p, q and t.
module hsvrgb_prod (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvrgb_pkg::s1_type     in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvrgb_pkg::s3_type     out_data
);
   import hsvrgb_pkg::*;

   logic    s2_valid_ff, s2_valid_in, s2_ready;
   s2_type  s2_ff, s2_in;
   logic    s3_valid_ff, s3_valid_in, s3_ready;
   s3_type  s3_ff, s3_in;

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign in_ready  = s2_ready;
   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

   always_comb begin
      s2_in.sector = in_data.sector;
      s2_in.v      = in_data.v;
      s2_in.p      = fx_mul(in_data.v, ONE_F - in_data.s);
      s2_in.fs     = fx_mul({1'b0, in_data.f}, in_data.s);
      s2_in.gs     = fx_mul(ONE_F - {1'b0, in_data.f}, in_data.s);
      s2_valid_in  = s2_ready ? in_valid : s2_valid_ff;
   end

   always_comb begin
      s3_in.sector = s2_ff.sector;
      s3_in.v      = s2_ff.v;
      s3_in.p      = s2_ff.p;
      s3_in.q      = fx_mul(s2_ff.v, ONE_F - s2_ff.fs);
      s3_in.t      = fx_mul(s2_ff.v, ONE_F - s2_ff.gs);
      s3_valid_in  = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

endmodule

>>> hw/rtl/hsvrgb_out.sv
// Last stage: route by sector, scale to eight-bit channels, hold the result.
module hsvrgb_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvrgb_pkg::s3_type     in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [3*hsvrgb_pkg::CH_BITS-1:0] out_rgb
);
   import hsvrgb_pkg::*;

   logic                       valid_ff, valid_in;
   logic [3*CH_BITS-1:0]       rgb_ff, rgb_in;
   logic [FRAC_BITS:0]         r, g, b;

   function automatic logic [CH_BITS-1:0] to_channel(input logic [FRAC_BITS:0] x);
      logic [FRAC_BITS+CH_BITS:0] scaled;
      logic [FRAC_BITS+CH_BITS:0] c;
      scaled = ((FRAC_BITS + CH_BITS + 1)'(x) << CH_BITS) - (FRAC_BITS + CH_BITS + 1)'(x);
      c      = scaled >> FRAC_BITS;
      return (c > (FRAC_BITS + CH_BITS + 1)'(CH_MAX)) ? CH_MAX : c[CH_BITS-1:0];
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rgb   = rgb_ff;

   always_comb begin
      case (in_data.sector)
         SEC_RED_YELLOW: begin
            r = in_data.v; g = in_data.t; b = in_data.p;
         end
         SEC_YELLOW_GREEN: begin
            r = in_data.q; g = in_data.v; b = in_data.p;
         end
         SEC_GREEN_CYAN: begin
            r = in_data.p; g = in_data.v; b = in_data.t;
         end
         SEC_CYAN_BLUE: begin
            r = in_data.p; g = in_data.q; b = in_data.v;
         end
         SEC_BLUE_MAGENTA: begin
            r = in_data.t; g = in_data.p; b = in_data.v;
         end
         default: begin
            r = in_data.v; g = in_data.p; b = in_data.q;
         end
      endcase
      rgb_in   = {to_channel(b), to_channel(g), to_channel(r)};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rgb_ff <= rgb_in;
      end
   end

endmodule

>>> hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter: four register stages, one request per cycle unless the output stalls.
// The two product levels sit in stages two and three.
// A stall holds every full stage whose successor cannot take its data; bubbles close up.
// Reset (synchronous) empties the pipeline; no other state is kept.
`include "hsv_to_rgb_converter_macros.svh"
module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // hue_fraction [15:0], saturation [32:16], brightness [49:33], zero [55:50]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red [7:0], green [15:8], blue [23:16]
   output logic [23:0] rsp_tdata
);
   import hsvrgb_pkg::*;

   logic    s1_valid, s1_ready;
   s1_type  s1_data;
   logic    s3_valid, s3_ready;
   s3_type  s3_data;

   hsvrgb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .hue       (req_tdata[15:0]),
      .sat       (req_tdata[32:16]),
      .bri       (req_tdata[49:33]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   hsvrgb_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   hsvrgb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rgb   (rsp_tdata)
   );

   // a full pipeline is the only reason to refuse a request
   `ASSERT_IMPLIES(a_backpressure_only_when_full, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready && s3_valid && s1_valid)
   // every channel source is bounded by the value
   `ASSERT_IMPLIES(a_products_below_value, clock, reset, s3_valid,
      s3_data.p <= s3_data.v && s3_data.q <= s3_data.v && s3_data.t <= s3_data.v)
   // a stalled product stage keeps its contents
   `ASSERT_NEXT(a_stage3_holds, clock, reset, s3_valid && !s3_ready,
      s3_valid && $stable(s3_data))

endmodule

>>> dv/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to RGB converter stream block.
module tb_hsv_to_rgb_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import hsvrgb_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_REQS  = 1100;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_LIMIT   = 2000;

   // packed top-down so that {zero pad, hsv_req_t} matches req_tdata
   typedef struct packed {
      logic [16:0] val;
      logic [16:0] sat;
      logic [15:0] hue;
   } hsv_req_t;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_t;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // hue_fraction [15:0], saturation [32:16], brightness [49:33], zero [55:50]
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // red [7:0], green [15:8], blue [23:16]
   logic [23:0] rsp_tdata;

   hsv_req_t pending_reqs[$];
   rgb_t     rgb_expected[$];
   hsv_req_t cur_req = '0;
   logic     req_went = 1'b0;

   int burst_left = 0;
   int gap_left = 0;
   rx_mode_t rx_mode = RX_ALWAYS;
   int rx_left = 0;
   int rx_tick = 0;
   int idle_cycles = 0;
   int fail_count = 0;
   int n_directed = 0;
   int n_reqs = 0;
   int n_rsps = 0;
   int n_clamped = 0;
   int n_stalls = 0;

   hsv_to_rgb_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Q.16 input to the working fraction width
   function automatic logic [63:0] widen_frac(input logic [63:0] x);
      return (x << SHL) >> SHR;
   endfunction

   function automatic logic [63:0] frac_product(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic logic [7:0] colour_byte(input logic [63:0] x);
      logic [63:0] c;
      c = (x * 64'd255) >> FRAC_BITS;
      return (c > 64'd255) ? 8'hFF : c[7:0];
   endfunction

   function automatic rgb_t hsv_to_rgb_expect(input hsv_req_t x);
      logic [63:0] unit, h, s, v, hf, f, p, q, t, r, g, b;
      sector_type  sec;
      rgb_t        res;
      unit = 64'd1 << FRAC_BITS;
      s = widen_frac((x.sat > ONE_IN) ? 64'(ONE_IN) : 64'(x.sat));
      v = widen_frac((x.val > ONE_IN) ? 64'(ONE_IN) : 64'(x.val));
      h = widen_frac(64'(x.hue));
      hf = h * 64'd6;
      sec = sector_type'(3'(hf >> FRAC_BITS));
      f = hf & (unit - 64'd1);
      p = frac_product(v, unit - s);
      q = frac_product(v, unit - frac_product(f, s));
      t = frac_product(v, unit - frac_product(unit - f, s));
      case (sec)
         SEC_RED_YELLOW: begin
            r = v; g = t; b = p;
         end
         SEC_YELLOW_GREEN: begin
            r = q; g = v; b = p;
         end
         SEC_GREEN_CYAN: begin
            r = p; g = v; b = t;
         end
         SEC_CYAN_BLUE: begin
            r = p; g = q; b = v;
         end
         SEC_BLUE_MAGENTA: begin
            r = t; g = p; b = v;
         end
         default: begin
            r = v; g = p; b = q;
         end
      endcase
      res.red   = colour_byte(r);
      res.green = colour_byte(g);
      res.blue  = colour_byte(b);
      return res;
   endfunction

   // mostly in range, with a share of clamped and edge values
   function automatic logic [16:0] random_unit_q16();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 17'($urandom_range(0, 65536));
         6, 7:             return 17'($urandom_range(0, 17'h1FFFF));
         8:                return ($urandom_range(0, 1) != 0) ? 17'h10000 : 17'h0;
         default:          return 17'(65536 - $urandom_range(0, 3));
      endcase
   endfunction

   // request driver: bursts of random length with random gaps
   always @(negedge clock) begin : drive_reqs
      hsv_req_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_went) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         nxt = pending_reqs.pop_front();
         cur_req <= nxt;
         req_tdata <= {6'b0, nxt};
         req_tvalid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response back-pressure: switch between stall patterns now and then
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_left == 0) begin
         rx_mode <= rx_mode_t'($urandom_range(0, 3));
         rx_left <= $urandom_range(50, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= ((rx_tick % 32) < 8);
      endcase
   end

   always @(posedge clock) begin : check_rgb
      rgb_t got;
      rgb_t want;
      if (reset) begin
         req_went <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_went <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            rgb_expected.push_back(hsv_to_rgb_expect(cur_req));
            n_reqs++;
            if (cur_req.sat > ONE_IN || cur_req.val > ONE_IN)
               n_clamped++;
         end
         if (rsp_tvalid && !rsp_tready)
            n_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            n_rsps++;
            if (rgb_expected.size() == 0) begin
               $error("unexpected response %h with no request outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = rgb_expected.pop_front();
               if (got.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, got.red);
                  fail_count++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, got.green);
                  fail_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, got.blue);
                  fail_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     idle_cycles, rgb_expected.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      // sector boundaries, greys, black, clamping and alternating bit patterns
      pending_reqs.push_back('{hue: 16'd0,     sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'hFFFF,  sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd10922, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd10923, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd21845, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd21846, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd32767, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd32768, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd43690, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd43691, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd54613, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd54614, sat: 17'h10000, val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd12345, sat: 17'h0,     val: 17'h10000});
      pending_reqs.push_back('{hue: 16'd40000, sat: 17'h10000, val: 17'h0});
      pending_reqs.push_back('{hue: 16'd20000, sat: 17'h1FFFF, val: 17'h1FFFF});
      pending_reqs.push_back('{hue: 16'd50000, sat: 17'h10001, val: 17'd40000});
      pending_reqs.push_back('{hue: 16'd5000,  sat: 17'd30000, val: 17'h10001});
      pending_reqs.push_back('{hue: 16'd30000, sat: 17'hFFFF,  val: 17'hFFFF});
      pending_reqs.push_back('{hue: 16'd1,     sat: 17'h1,     val: 17'h1});
      pending_reqs.push_back('{hue: 16'hAAAA,  sat: 17'h15555, val: 17'h0AAAA});
      pending_reqs.push_back('{hue: 16'h5555,  sat: 17'h0AAAA, val: 17'h15555});
      n_directed = pending_reqs.size();
      for (int i = 0; i < RANDOM_REQS; i++) begin
         pending_reqs.push_back('{hue: 16'($urandom_range(0, 65535)),
                                  sat: random_unit_q16(),
                                  val: random_unit_q16()});
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid || rgb_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("converted %0d colours (%0d directed, %0d with clamped inputs), %0d checked",
               n_reqs, n_directed, n_clamped, n_rsps);
      $display("output held under back-pressure for %0d cycles", n_stalls);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_prep.sv
hw/rtl/hsvrgb_prod.sv
hw/rtl/hsvrgb_out.sv
hw/rtl/hsv_to_rgb_converter.sv
dv/tb_hsv_to_rgb_converter.sv
